// ===== hw/rtl/wtip_pkg.sv =====
// Package for the world-to-image projection block: payload structs, codes, widths.
// No dependencies; used by every file under hw/rtl.
package wtip_pkg;

	localparam int NumRegs = 8;
	localparam int AddrW   = 6;
	localparam int HW      = 66;   // homogeneous coordinate width
	localparam int QW      = 48;   // clamped Q16.16 ratio, signed
	localparam int QMagW   = 47;   // ratio magnitude up to 2^46
	localparam int NumW    = 81;   // dividend magnitude with 16 fraction bits
	localparam int DenW    = 65;
	localparam int DivSteps = 3;   // iterations per divider stage
	localparam int DivStages = 27; // 81 quotient bits over all stages

	localparam logic [1:0] OP_SCREEN = 2'd0;
	localparam logic [1:0] OP_NORM   = 2'd1;
	localparam logic [1:0] OP_PIXEL  = 2'd2;

	localparam logic [63:0] RST_DIAG0 = 64'd16777216;
	localparam logic [63:0] RST_DIAG1 = 64'd72057594037927936;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [12:0]        image_width;
		logic [12:0]        image_height;
		logic               flip_vertical;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_depth;
		logic               w_is_zero;
		logic               saturated;
	} out_word_t;

	// Side data that rides alongside the dividers.
	typedef struct packed {
		logic [1:0]  operation;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        flip_vertical;
		logic        w_zero;
	} side_t;

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
		output logic sat);
		sat = 1'b0;
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// ===== hw/rtl/wtip_div.sv =====
// Pipelined signed ratio unit: Q16.16 quotient of n/d, truncated, clamped to 2^46.
// Depends on wtip_pkg. Restoring division, a few bits per register stage.
module wtip_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [wtip_pkg::HW-1:0]  num,
	input  logic signed [wtip_pkg::HW-1:0]  den,
	output logic signed [wtip_pkg::QW-1:0]  ratio
);
	localparam int NW = wtip_pkg::NumW;
	localparam int DW = wtip_pkg::DenW;
	localparam int S  = wtip_pkg::DivStages;
	localparam int K  = wtip_pkg::DivSteps;

	logic [NW-1:0] quo_q [S+1];
	logic [DW-1:0] rem_q [S+1];
	logic [DW-1:0] den_q [S+1];
	logic          neg_q [S+1];

	logic [DW-1:0] un, ud;

	always_comb begin
		un = num[wtip_pkg::HW-1] ? DW'(-num) : DW'(num);
		ud = den[wtip_pkg::HW-1] ? DW'(-den) : DW'(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q[0] <= {un, 16'd0};
			rem_q[0] <= '0;
			den_q[0] <= ud;
			neg_q[0] <= num[wtip_pkg::HW-1] ^ den[wtip_pkg::HW-1];
		end
	end

	for (genvar g = 0; g < S; g++) begin : g_stage
		logic [NW-1:0] qn;
		logic [DW-1:0] rn;
		logic [DW:0]   t;
		always_comb begin
			qn = quo_q[g];
			rn = rem_q[g];
			t  = '0;
			for (int i = 0; i < K; i++) begin
				t  = {rn, qn[NW-1]};
				qn = {qn[NW-2:0], 1'b0};
				if (t >= {1'b0, den_q[g]}) begin
					t = t - {1'b0, den_q[g]};
					qn[0] = 1'b1;
				end
				rn = t[DW-1:0];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[g+1] <= qn;
				rem_q[g+1] <= rn;
				den_q[g+1] <= den_q[g];
				neg_q[g+1] <= neg_q[g];
			end
		end
	end

	logic [wtip_pkg::QMagW-1:0] mag;
	always_comb begin
		if (quo_q[S] >= NW'(64'h0000_4000_0000_0000))
			mag = wtip_pkg::QMagW'(64'h0000_4000_0000_0000);
		else
			mag = quo_q[S][wtip_pkg::QMagW-1:0];
		ratio = neg_q[S] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end
endmodule

// ===== hw/rtl/world_to_image_projection.sv =====
// Top level of the world-to-image projection block: registers, transform, dividers, output.
// Depends on wtip_pkg and wtip_div.
//
//  channel  | signals                              | handshake
//  config   | psel penable pwrite paddr pwdata     | APB, pready tied high
//  input    | start, busy, in_word                 | taken when start && !busy
//  result   | done, out_word                       | one-cycle strobe, no stall
//
// One word may enter every cycle; busy is never raised.
// The pipeline has one multiply stage, one sum stage, the divider input register,
// 27 divider stages of three quotient bits each, one mode stage and the output register.
// Reset clears the valid chain and loads the identity matrix.
// The receiver cannot stall, so the pipeline always advances.
module world_to_image_projection (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wtip_pkg::AddrW-1:0]   paddr,
	input  logic [63:0]                  pwdata,
	output logic [63:0]                  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  wtip_pkg::in_word_t           in_word,
	output logic                         done,
	output wtip_pkg::out_word_t          out_word
);
	localparam int LAT = wtip_pkg::DivStages + 1;

	logic [63:0] regs_q [wtip_pkg::NumRegs];

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign prdata = regs_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= wtip_pkg::RST_DIAG0;
			regs_q[1] <= '0;
			regs_q[2] <= wtip_pkg::RST_DIAG1;
			regs_q[3] <= '0;
			regs_q[4] <= '0;
			regs_q[5] <= wtip_pkg::RST_DIAG0;
			regs_q[6] <= '0;
			regs_q[7] <= wtip_pkg::RST_DIAG1;
		end else if (psel && penable && pwrite && pready) begin
			regs_q[paddr[5:3]] <= pwdata;
		end
	end

	logic accept;
	assign accept = start && !busy;

	// Stage 1: twelve products.
	logic signed [63:0] prod_s1 [4][3];
	logic signed [65:0] bias_s1 [4];
	wtip_pkg::in_word_t in_s1;
	logic v_s1, v_s2;
	logic [LAT-1:0] v_div_q;
	logic v_s4, v_s5;

	function automatic logic signed [31:0] ent(input logic [63:0] r, input logic hi);
		return hi ? r[63:32] : r[31:0];
	endfunction

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			prod_s1[r][0] <= ent(regs_q[2*r], 1'b0) * in_word.point_x;
			prod_s1[r][1] <= ent(regs_q[2*r], 1'b1) * in_word.point_y;
			prod_s1[r][2] <= ent(regs_q[2*r+1], 1'b0) * in_word.point_z;
			bias_s1[r]    <= 66'(ent(regs_q[2*r+1], 1'b1)) <<< 8;
		end
		in_s1 <= in_word;
	end

	// Stage 2: sums of floored terms.
	logic signed [wtip_pkg::HW-1:0] h_s2 [4];
	wtip_pkg::in_word_t in_s2;
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++)
			h_s2[r] <= bias_s1[r] + 66'(prod_s1[r][0] >>> 8) + 66'(prod_s1[r][1] >>> 8)
				+ 66'(prod_s1[r][2] >>> 8);
		in_s2 <= in_s1;
	end

	logic signed [wtip_pkg::QW-1:0] rx, ry, rz;
	wtip_pkg::side_t side_q [LAT];
	logic w0;
	assign w0 = (h_s2[3] == '0);

	wtip_div u_div_x (.clk, .en(1'b1), .num(h_s2[0]), .den(h_s2[3]), .ratio(rx));
	wtip_div u_div_y (.clk, .en(1'b1), .num(h_s2[1]), .den(h_s2[3]), .ratio(ry));
	wtip_div u_div_z (.clk, .en(1'b1), .num(h_s2[2]), .den(h_s2[3]), .ratio(rz));

	always_ff @(posedge clk) begin
		side_q[0] <= '{operation: in_s2.operation, image_width: in_s2.image_width,
			image_height: in_s2.image_height, flip_vertical: in_s2.flip_vertical,
			w_zero: w0};
		for (int i = 1; i < LAT; i++)
			side_q[i] <= side_q[i-1];
	end

	// Stage after divider: offsets and pixel products.
	logic signed [63:0] ox_s4, oy_s4;
	logic signed [wtip_pkg::QW-1:0] rz_s4;
	wtip_pkg::side_t sd_s4;
	logic signed [49:0] ax, ay;
	logic signed [63:0] px, py;
	always_comb begin
		ax = 50'(rx) + 50'sd65536;
		ay = side_q[LAT-1].flip_vertical ? 50'sd65536 - 50'(ry) : 50'(ry) + 50'sd65536;
		px = $signed({1'b0, side_q[LAT-1].image_width}) * ax;
		py = $signed({1'b0, side_q[LAT-1].image_height}) * ay;
	end
	always_ff @(posedge clk) begin
		unique case (side_q[LAT-1].operation)
			wtip_pkg::OP_NORM: begin
				ox_s4 <= 64'(ax >>> 1);
				oy_s4 <= 64'((50'sd65536 - 50'(ry)) >>> 1);
			end
			wtip_pkg::OP_PIXEL: begin
				ox_s4 <= px >>> 1;
				oy_s4 <= py >>> 1;
			end
			default: begin
				ox_s4 <= 64'(rx);
				oy_s4 <= 64'(ry);
			end
		endcase
		rz_s4 <= rz;
		sd_s4 <= side_q[LAT-1];
	end

	// Output register.
	logic sx, sy, sz;
	logic signed [31:0] cx, cy, cz;
	always_comb begin
		cx = wtip_pkg::clamp32(ox_s4, sx);
		cy = wtip_pkg::clamp32(oy_s4, sy);
		cz = wtip_pkg::clamp32(64'(rz_s4), sz);
	end
	always_ff @(posedge clk) begin
		if (sd_s4.w_zero) begin
			out_word <= '{out_x: '0, out_y: '0, out_depth: '0, w_is_zero: 1'b1,
				saturated: 1'b0};
		end else begin
			out_word <= '{out_x: cx, out_y: cy, out_depth: cz, w_is_zero: 1'b0,
				saturated: sx | sy | sz};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_div_q <= '0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
		end else begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_div_q <= {v_div_q[LAT-2:0], v_s2};
			v_s4    <= v_div_q[LAT-1];
			v_s5    <= v_s4;
		end
	end
	assign done = v_s5;
endmodule

// ===== hw/rtl/wtip_checker.sv =====
// Port-level checker for the world-to-image projection block, with its bind.
// Depends on wtip_pkg.
module wtip_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic                pready,
	input wtip_pkg::out_word_t out_word
);
	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_word.w_is_zero |-> out_word.out_x == 0 && out_word.out_y == 0
		&& out_word.out_depth == 0 && !out_word.saturated)
		else $error("zero w word carries data");
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##32 done)
		else $error("word lost in pipeline");
endmodule

bind world_to_image_projection wtip_checker u_chk (.clk, .arst_n, .start, .busy, .done,
	.pready, .out_word);

// ===== bench/world_to_image_projection_tb.sv =====
// Self-checking bench for world_to_image_projection: APB matrix set-up, point words, results.
// Depends on wtip_pkg and the block's RTL; expected results come from a predictor in this file.
`timescale 1ns / 1ps

module world_to_image_projection_tb;

	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles   = 40;
	localparam logic [1:0] OpReserved = 2'd3;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [wtip_pkg::AddrW-1:0]  paddr;
	logic [63:0]                 pwdata;
	logic [63:0]                 prdata;
	logic                        pready;
	logic                        start;
	logic                        busy;
	wtip_pkg::in_word_t          in_word;
	logic                        done;
	wtip_pkg::out_word_t         out_word;

	logic [63:0]                 matrix_regs [wtip_pkg::NumRegs];
	wtip_pkg::out_word_t         pending_results [$];
	int                          errors;
	int                          idle_count;
	bit                          idling_on;

	world_to_image_projection uut (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic signed [95:0] mat_entry(int r, int c);
		logic [63:0] reg_val;
		reg_val = matrix_regs[r * 2 + c / 2];
		return (c % 2) ? 96'($signed(reg_val[63:32])) : 96'($signed(reg_val[31:0]));
	endfunction

	// Q16.16 quotient, truncated toward zero, magnitude held at 2^46.
	function automatic logic signed [95:0] ratio_q16(logic signed [95:0] n,
		logic signed [95:0] d);
		logic        neg;
		logic [95:0] un, ud, q;
		neg = (n < 0) != (d < 0);
		un  = (n < 0) ? -n : n;
		ud  = (d < 0) ? -d : d;
		q   = (un << 16) / ud;
		if (q > (96'd1 << 46))
			q = 96'd1 << 46;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [31:0] sat32(logic signed [95:0] v, ref logic sat);
		if (v > 96'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end else if (v < -96'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic wtip_pkg::out_word_t project_point(wtip_pkg::in_word_t w);
		logic signed [95:0] pt [3];
		logic signed [95:0] hom [4];
		logic signed [95:0] rx, ry, rz, ox, oy, wi, hi;
		logic               sat;
		wtip_pkg::out_word_t res;
		pt[0] = 96'(w.point_x);
		pt[1] = 96'(w.point_y);
		pt[2] = 96'(w.point_z);
		for (int r = 0; r < 4; r++) begin
			hom[r] = mat_entry(r, 3) * 96'sd256;
			for (int c = 0; c < 3; c++)
				hom[r] = hom[r] + ((mat_entry(r, c) * pt[c]) >>> 8);
		end
		res = '0;
		if (hom[3] == 0) begin
			res.w_is_zero = 1'b1;
			return res;
		end
		rx = ratio_q16(hom[0], hom[3]);
		ry = ratio_q16(hom[1], hom[3]);
		rz = ratio_q16(hom[2], hom[3]);
		wi = $signed({83'd0, w.image_width});
		hi = $signed({83'd0, w.image_height});
		case (w.operation)
			wtip_pkg::OP_NORM: begin
				ox = (rx + 96'sd65536) >>> 1;
				oy = (96'sd65536 - ry) >>> 1;
			end
			wtip_pkg::OP_PIXEL: begin
				ox = (wi * (rx + 96'sd65536)) >>> 1;
				if (w.flip_vertical)
					oy = (hi * (96'sd65536 - ry)) >>> 1;
				else
					oy = (hi * (ry + 96'sd65536)) >>> 1;
			end
			default: begin
				ox = rx;
				oy = ry;
			end
		endcase
		sat = 1'b0;
		res.out_x     = sat32(ox, sat);
		res.out_y     = sat32(oy, sat);
		res.out_depth = sat32(rz, sat);
		res.saturated = sat;
		return res;
	endfunction

	// Accepted words are predicted at the edge that takes them.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pending_results.push_back(project_point(in_word));
	end

	always @(posedge clk) begin
		wtip_pkg::out_word_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_word);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (out_word.out_x !== exp_res.out_x) begin
					$display("%0t: out_x expected %h actual %h", $time,
						exp_res.out_x, out_word.out_x);
					errors++;
				end
				if (out_word.out_y !== exp_res.out_y) begin
					$display("%0t: out_y expected %h actual %h", $time,
						exp_res.out_y, out_word.out_y);
					errors++;
				end
				if (out_word.out_depth !== exp_res.out_depth) begin
					$display("%0t: out_depth expected %h actual %h", $time,
						exp_res.out_depth, out_word.out_depth);
					errors++;
				end
				if (out_word.w_is_zero !== exp_res.w_is_zero) begin
					$display("%0t: w_is_zero expected %b actual %b", $time,
						exp_res.w_is_zero, out_word.w_is_zero);
					errors++;
				end
				if (out_word.saturated !== exp_res.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						exp_res.saturated, out_word.saturated);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || psel)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WatchdogLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Each write leaves the bus idle before it returns, so that the next one starts cleanly.
	task automatic cfg_write(int idx, logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= wtip_pkg::AddrW'(idx * 8);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		matrix_regs[idx] = val;
		@(posedge clk);
	endtask

	// Leaves start high so that back-to-back words need no second assignment.
	task automatic send_point(wtip_pkg::in_word_t w);
		bit was_busy;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		start   <= 1'b1;
		in_word <= w;
		forever begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
			if (!was_busy)
				break;
		end
	endtask

	task automatic drain_pipeline();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
			2: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
			3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 2 << 24)) - (1 << 24));
		endcase
	endfunction

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 << 24)) - (1 << 24));
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic wtip_pkg::in_word_t rand_point();
		wtip_pkg::in_word_t w;
		w.operation     = 2'($urandom_range(0, 3));
		w.point_x       = rand_coord();
		w.point_y       = rand_coord();
		w.point_z       = rand_coord();
		w.image_width   = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 4096));
		w.image_height  = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 4096));
		w.flip_vertical = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic wtip_pkg::in_word_t make_point(logic [1:0] op, logic [31:0] x,
		logic [31:0] y, logic [31:0] z, logic [12:0] wd, logic [12:0] ht, logic flip);
		wtip_pkg::in_word_t w;
		w = '{op, x, y, z, wd, ht, flip};
		return w;
	endfunction

	// Identity matrix after reset: every mode, field extremes and the flip.
	task automatic test_directed_identity();
		send_point(make_point(wtip_pkg::OP_SCREEN, 32'h00010000, 32'hffff0000, 32'h00008000,
			13'd640, 13'd480, 1'b0));
		send_point(make_point(wtip_pkg::OP_NORM, 32'h00008000, 32'h00008000, 32'h0, 13'd1,
			13'd1, 1'b1));
		send_point(make_point(wtip_pkg::OP_PIXEL, 32'h00008000, 32'hffff8000, 32'h0, 13'd4096,
			13'd4096, 1'b0));
		send_point(make_point(wtip_pkg::OP_PIXEL, 32'h00008000, 32'hffff8000, 32'h0, 13'd4096,
			13'd4096, 1'b1));
		send_point(make_point(wtip_pkg::OP_PIXEL, 32'h00010000, 32'h00010000, 32'h0, 13'd0,
			13'd0, 1'b1));
		send_point(make_point(wtip_pkg::OP_PIXEL, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			13'h1fff, 13'h1fff, 1'b0));
		send_point(make_point(OpReserved, 32'h80000000, 32'h7fffffff, 32'h80000000, 13'h1fff,
			13'h1fff, 1'b1));
		send_point(make_point(wtip_pkg::OP_NORM, 32'h7fffffff, 32'h80000000, 32'h0, 13'd0,
			13'd0, 1'b0));
		send_point(make_point(wtip_pkg::OP_SCREEN, 32'h0, 32'h0, 32'h0, 13'd0, 13'd0, 1'b0));
		drain_pipeline();
	endtask

	// A zero bottom row forces w to zero; a tiny w term drives large ratios.
	task automatic test_zero_and_tiny_w();
		cfg_write(6, 64'd0);
		cfg_write(7, 64'd0);
		send_point(make_point(wtip_pkg::OP_SCREEN, 32'h7fffffff, 32'h1, 32'h2, 13'd5, 13'd5,
			1'b0));
		send_point(make_point(wtip_pkg::OP_PIXEL, 32'h80000000, 32'h80000000, 32'h80000000,
			13'h1fff, 13'h1fff, 1'b1));
		drain_pipeline();
		cfg_write(7, {32'h00000001, 32'h0});
		send_point(make_point(wtip_pkg::OP_SCREEN, 32'h00010000, 32'h00010000, 32'h00010000,
			13'd1, 13'd1, 1'b0));
		send_point(make_point(wtip_pkg::OP_NORM, 32'h0, 32'h0, 32'h0, 13'd1, 13'd1, 1'b0));
		drain_pipeline();
		cfg_write(7, {32'hffffffff, 32'h0});
		send_point(make_point(wtip_pkg::OP_PIXEL, 32'h00000100, 32'hffffff00, 32'h0, 13'd100,
			13'd100, 1'b1));
		drain_pipeline();
	endtask

	task automatic load_matrix(int kind);
		for (int i = 0; i < wtip_pkg::NumRegs; i++) begin
			case (kind)
				0: cfg_write(i, {32'h7fffffff, 32'h7fffffff});
				1: cfg_write(i, {32'h80000000, 32'h80000000});
				2: cfg_write(i, (i == 0 || i == 5) ? wtip_pkg::RST_DIAG0 :
					(i == 2 || i == 7) ? wtip_pkg::RST_DIAG1 : 64'd0);
				default: cfg_write(i, {rand_entry(), rand_entry()});
			endcase
		end
	endtask

	task automatic test_random_points(int kind, int count);
		load_matrix(kind);
		for (int n = 0; n < count; n++)
			send_point(rand_point());
		drain_pipeline();
	endtask

	initial begin
		errors    = 0;
		idle_count = 0;
		idling_on = 1'b1;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		start     = 1'b0;
		in_word   = '0;
		matrix_regs[0] = wtip_pkg::RST_DIAG0;
		matrix_regs[1] = 64'd0;
		matrix_regs[2] = wtip_pkg::RST_DIAG1;
		matrix_regs[3] = 64'd0;
		matrix_regs[4] = 64'd0;
		matrix_regs[5] = wtip_pkg::RST_DIAG0;
		matrix_regs[6] = 64'd0;
		matrix_regs[7] = wtip_pkg::RST_DIAG1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_identity();
		test_zero_and_tiny_w();
		test_random_points(0, 100);
		test_random_points(1, 100);
		test_random_points(2, 250);
		for (int s = 0; s < 4; s++)
			test_random_points(3, 200);
		idling_on = 1'b0;
		test_random_points(3, 385);

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
